@@ src/mset_pkg.sv @@
package mset_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_BITS = 4;
   localparam int TIME_BITS = 48;
   localparam int PROD_BITS = 42;
   localparam logic [9:0] MS_PER_S = 10'd1000;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_EPOCH = 2'd3;

   localparam logic [1:0] MODE_PERIODIC = 2'd1;
   localparam logic [1:0] MODE_ABSOLUTE = 2'd2;

   localparam int REQ_DATA_BITS = 152;
   localparam int RSP_DATA_BITS = 88;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_START,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic start;
      logic scan_step;
      logic done_emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_start;
      logic last_slot;
      logic out_free;
   } ctl_sts_type;

endpackage

@@ src/mset_ctrl.sv @@
module mset_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mset_pkg::ctl_sts_type sts,
   output mset_pkg::ctl_cmd_type cmd
);
   import mset_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = sts.is_start ? ST_START : ST_SCAN;
         end
         ST_START: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.out_free && sts.last_slot) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_PREP:  cmd.prep = 1'b1;
         ST_START: cmd.start = 1'b1;
         ST_SCAN:  cmd.scan_step = sts.out_free;
         ST_DONE:  cmd.done_emit = sts.out_free;
         default: ;
      endcase
   end

endmodule

@@ src/mset_datapath.sv @@
module mset_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mset_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [1:0]                          req_tuser,
   input  mset_pkg::ctl_cmd_type               cmd,
   output mset_pkg::ctl_sts_type               sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mset_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import mset_pkg::*;

   logic [1:0]           op_ff;
   logic [3:0]           slot_ff;
   logic [1:0]           mode_ff;
   logic [31:0]          sec_ff;
   logic signed [15:0]   delta_ff;
   logic [31:0]          ev_ff;
   logic [31:0]          el_ff;
   logic [31:0]          ep_ff;

   logic [PROD_BITS-1:0] base_ff;
   logic [TIME_BITS-1:0] cur_ff;
   logic                 status_ff;
   logic [SLOT_BITS-1:0] idx_ff;
   logic                 any_ff;
   logic [TIME_BITS-1:0] nx_ff;

   logic                 act_ff [NUM_SLOTS];
   logic [1:0]           md_ff  [NUM_SLOTS];
   logic [TIME_BITS-1:0] rem_ff [NUM_SLOTS];
   logic [TIME_BITS-1:0] rld_ff [NUM_SLOTS];
   logic [31:0]          evs_ff [NUM_SLOTS];

   logic                 out_valid_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff;
   logic                 out_kind_ff;
   logic                 out_last_ff;

   logic [31:0]          mul_op;
   logic [PROD_BITS-1:0] prod;
   logic signed [43:0]   sval;
   logic [TIME_BITS-1:0] val;
   logic                 reject;
   logic                 s_act;
   logic [1:0]           s_md;
   logic [TIME_BITS-1:0] s_rem;
   logic [TIME_BITS-1:0] s_rld;
   logic [TIME_BITS-1:0] el_w;
   logic [TIME_BITS-1:0] nrem;
   logic                 fire;
   logic                 fin_act;
   logic [TIME_BITS-1:0] fin_rem;

   // one shared multiplier: start value or new epoch in ms
   assign mul_op = (op_ff == OP_START) ? sec_ff : ep_ff;
   assign prod   = PROD_BITS'(mul_op * MS_PER_S);

   always_comb begin
      sval = $signed({2'b00, base_ff}) + 44'(delta_ff);
      val  = TIME_BITS'(sval);
      reject = (sval <= 44'sd0) || act_ff[slot_ff]
         || ({28'd0, slot_ff} >= NUM_SLOTS)
         || ((mode_ff == MODE_ABSOLUTE) && (val <= cur_ff));
   end

   always_comb begin
      s_act = act_ff[idx_ff];
      s_md  = md_ff[idx_ff];
      s_rem = rem_ff[idx_ff];
      s_rld = rld_ff[idx_ff];
      el_w  = TIME_BITS'(el_ff);
      nrem  = s_rem;
      fire  = 1'b0;
      case (op_ff)
         OP_TICK: begin
            nrem = (s_rem >= el_w) ? s_rem - el_w : '0;
            fire = s_act && (nrem == '0);
         end
         OP_EPOCH: begin
            if (ep_ff != '0 && s_md == MODE_ABSOLUTE)
               nrem = (s_rld > cur_ff) ? s_rld - cur_ff : '0;
         end
         default: ;
      endcase
      fin_act = s_act && !(fire && s_md != MODE_PERIODIC);
      fin_rem = fire ? s_rld : nrem;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_tuser;
         slot_ff  <= req_tdata[3:0];
         mode_ff  <= req_tdata[5:4];
         sec_ff   <= req_tdata[37:6];
         delta_ff <= req_tdata[53:38];
         ev_ff    <= req_tdata[85:54];
         el_ff    <= req_tdata[117:86];
         ep_ff    <= req_tdata[149:118];
      end
      if (cmd.prep) base_ff <= prod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) act_ff[i] <= 1'b0;
      end else begin
         if (cmd.prep) begin
            if (op_ff == OP_TICK)
               cur_ff <= cur_ff + el_w;
            else if (op_ff == OP_EPOCH && ep_ff != '0)
               cur_ff <= TIME_BITS'(prod);
            else if (op_ff == OP_STOP && {28'd0, slot_ff} < NUM_SLOTS)
               act_ff[slot_ff[SLOT_BITS-1:0]] <= 1'b0;
         end
         if (cmd.start && !reject) act_ff[slot_ff] <= 1'b1;
         if (cmd.scan_step) act_ff[idx_ff] <= fin_act;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && !reject) begin
         rem_ff[slot_ff] <= (mode_ff == MODE_ABSOLUTE) ? val - cur_ff : val;
         rld_ff[slot_ff] <= val;
         md_ff[slot_ff]  <= mode_ff;
         evs_ff[slot_ff] <= ev_ff;
      end
      if (cmd.scan_step && s_act) rem_ff[idx_ff] <= fin_rem;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         status_ff <= 1'b0;
         idx_ff    <= '0;
         any_ff    <= 1'b0;
         nx_ff     <= '0;
      end
      if (cmd.start) status_ff <= reject;
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (fin_act) begin
            any_ff <= 1'b1;
            if (!any_ff || fin_rem < nx_ff) nx_ff <= fin_rem;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((cmd.scan_step && fire) || cmd.done_emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && fire) begin
         out_kind_ff <= 1'b1;
         out_last_ff <= 1'b0;
         out_data_ff <= {52'd0, evs_ff[idx_ff], idx_ff};
      end else if (cmd.done_emit) begin
         out_kind_ff <= 1'b0;
         out_last_ff <= 1'b1;
         out_data_ff <= {2'd0, nx_ff, any_ff, status_ff, 36'd0};
      end
   end

   assign sts.is_start  = (op_ff == OP_START);
   assign sts.last_slot = ({28'd0, idx_ff} == NUM_SLOTS - 1);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ src/multi_slot_event_timer_unit.sv @@
// bank of sixteen timer slots (one-shot, periodic or absolute epoch). each
// request word runs through a short prepare step (one shared 32x10 multiply
// for seconds*1000 or epoch*1000), a start decision for starts, then a scan
// of all slots, one slot per cycle while the result side is free, that
// counts down, fires and reloads (or rebases absolute slots on a new epoch),
// and tracks the earliest remaining time; a completion word with tlast ends
// every request, and a new request is taken only after that word is issued.
// fired words come out in ascending slot order, tuser high.
module multi_slot_event_timer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot[3:0] mode[5:4] seconds[37:6] delta_ms[53:38] event_code[85:54]
   // elapsed_ms[117:86] new_epoch_s[149:118], rest zero
   input  logic [mset_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // opcode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fired_slot[3:0] fired_event[35:4] status[36] any_active[37]
   // next_expiry_ms[85:38], rest zero
   output logic [mset_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // kind[0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import mset_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer
   mset_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // slot storage, clock, scan and result register
   mset_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // a fired word never closes a request
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("fired word marked last");

   // completion word carries no slot or event
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (!rsp_tuser && rsp_tdata[35:0] == 36'd0))
      else $error("completion word malformed");

endmodule

@@ dv/multi_slot_event_timer_unit_test.sv @@
`timescale 1ns / 1ps

module multi_slot_event_timer_unit_test;
   import mset_pkg::*;

   localparam logic [1:0] MODE_ONE_SHOT = 2'd0;
   localparam logic [1:0] MODE_THREE    = 2'd3;
   localparam logic [47:0] TIME_MAX     = {48{1'b1}};

   // one expected response word
   typedef struct packed {
      logic        kind;
      logic [3:0]  fired_slot;
      logic [31:0] fired_event;
      logic        status;
      logic        any_active;
      logic [47:0] next_expiry_ms;
      logic        last;
   } timer_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // slot, mode, seconds, delta_ms, event_code, elapsed_ms, new_epoch_s, zero pad
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // opcode
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // fired_slot, fired_event, status, any_active, next_expiry_ms, zero pad
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // kind
   logic rsp_tuser;
   logic rsp_tlast;

   multi_slot_event_timer_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the timer bank
   logic        shadow_active [NUM_SLOTS];
   logic [1:0]  shadow_mode [NUM_SLOTS];
   logic [47:0] shadow_remaining [NUM_SLOTS];
   logic [47:0] shadow_reload [NUM_SLOTS];
   logic [31:0] shadow_event [NUM_SLOTS];
   logic [47:0] shadow_now;

   timer_word_type pending_words [$];
   int  error_count = 0;
   bit  stall_enable = 1'b1;
   int  rsp_wait = 0;

   // arm a slot, returns 1 when the start is rejected
   function automatic logic arm_slot(logic [3:0] s, logic [1:0] m, logic [31:0] secs,
                                     logic [15:0] dms, logic [31:0] ev);
      logic [63:0] base;
      logic [63:0] value;
      logic [63:0] mag;
      base = 64'(secs) * 64'd1000;
      if (shadow_active[s]) return 1'b1;
      if (dms[15]) begin
         mag = 64'h10000 - 64'(dms);
         if (base <= mag) return 1'b1;
         value = base - mag;
      end else begin
         value = base + 64'(dms);
         if (value == 0) return 1'b1;
      end
      if (value > 64'(TIME_MAX)) value = 64'(TIME_MAX);
      if (m == MODE_ABSOLUTE) begin
         if (value[47:0] <= shadow_now) return 1'b1;
         shadow_remaining[s] = value[47:0] - shadow_now;
      end else begin
         shadow_remaining[s] = value[47:0];
      end
      shadow_reload[s] = value[47:0];
      shadow_mode[s]   = m;
      shadow_event[s]  = ev;
      shadow_active[s] = 1'b1;
      return 1'b0;
   endfunction

   // advance the shadow bank by one request and queue its response words
   function automatic void predict_timer(logic [1:0] op, logic [3:0] s, logic [1:0] m,
                                         logic [31:0] secs, logic [15:0] dms,
                                         logic [31:0] ev, logic [31:0] elapsed,
                                         logic [31:0] epoch);
      timer_word_type w;
      logic        rejected;
      logic [63:0] prod;
      rejected = 1'b0;
      case (op)
         OP_START: rejected = arm_slot(s, m, secs, dms, ev);
         OP_STOP: shadow_active[s] = 1'b0;
         OP_TICK: begin
            shadow_now = shadow_now + 48'(elapsed);
            for (int i = 0; i < NUM_SLOTS; i++)
               if (shadow_active[i])
                  shadow_remaining[i] = (shadow_remaining[i] >= 48'(elapsed)) ?
                                        shadow_remaining[i] - 48'(elapsed) : '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (shadow_active[i] && shadow_remaining[i] == 0) begin
                  w = '0;
                  w.kind = 1'b1;
                  w.fired_slot = 4'(i);
                  w.fired_event = shadow_event[i];
                  pending_words.push_back(w);
                  if (shadow_mode[i] == MODE_PERIODIC) shadow_remaining[i] = shadow_reload[i];
                  else shadow_active[i] = 1'b0;
               end
            end
         end
         default: begin
            if (epoch != 0) begin
               prod = 64'(epoch) * 64'd1000;
               shadow_now = prod[47:0];
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (shadow_active[i] && shadow_mode[i] == MODE_ABSOLUTE)
                     shadow_remaining[i] = (shadow_reload[i] > shadow_now) ?
                                           shadow_reload[i] - shadow_now : '0;
            end
         end
      endcase
      w = '0;
      w.status = rejected;
      w.last = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!shadow_active[i]) continue;
         if (!w.any_active || shadow_remaining[i] < w.next_expiry_ms)
            w.next_expiry_ms = shadow_remaining[i];
         w.any_active = 1'b1;
      end
      pending_words.push_back(w);
   endfunction

   // send one request word, predicting at acceptance; valid stays up between
   // back-to-back words and drops only for an idle gap or a drain
   task automatic send_request(logic [1:0] op, logic [3:0] s, logic [1:0] m,
                               logic [31:0] secs, logic [15:0] dms, logic [31:0] ev,
                               logic [31:0] elapsed, logic [31:0] epoch);
      int gap;
      gap = stall_enable ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, epoch, elapsed, ev, dms, secs, m, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer(op, s, m, secs, dms, ev, elapsed, epoch);
   endtask

   task automatic start_slot(logic [3:0] s, logic [1:0] m, logic [31:0] secs,
                             logic [15:0] dms, logic [31:0] ev);
      send_request(OP_START, s, m, secs, dms, ev, $urandom, $urandom);
   endtask

   task automatic stop_slot(logic [3:0] s);
      send_request(OP_STOP, s, 2'($urandom), $urandom, 16'($urandom), $urandom,
                   $urandom, $urandom);
   endtask

   task automatic tick(logic [31:0] ms);
      send_request(OP_TICK, 4'($urandom), 2'($urandom), $urandom, 16'($urandom),
                   $urandom, ms, $urandom);
   endtask

   task automatic set_epoch(logic [31:0] secs);
      send_request(OP_EPOCH, 4'($urandom), 2'($urandom), $urandom, 16'($urandom),
                   $urandom, $urandom, secs);
   endtask

   task automatic drain_words();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // response side: random wait per word, compare against the oldest expectation
   always @(posedge clock) begin
      timer_word_type exp_w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word kind=%0d", rsp_tuser);
               error_count++;
            end else begin
               exp_w = pending_words.pop_front();
               if (rsp_tuser !== exp_w.kind) begin
                  $error("kind exp %0d got %0d", exp_w.kind, rsp_tuser); error_count++;
               end
               if (rsp_tdata[3:0] !== exp_w.fired_slot) begin
                  $error("fired_slot exp %0d got %0d", exp_w.fired_slot, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[35:4] !== exp_w.fired_event) begin
                  $error("fired_event exp %h got %h", exp_w.fired_event, rsp_tdata[35:4]);
                  error_count++;
               end
               if (rsp_tdata[36] !== exp_w.status) begin
                  $error("status exp %0d got %0d", exp_w.status, rsp_tdata[36]);
                  error_count++;
               end
               if (rsp_tdata[37] !== exp_w.any_active) begin
                  $error("any_active exp %0d got %0d", exp_w.any_active, rsp_tdata[37]);
                  error_count++;
               end
               if (rsp_tdata[85:38] !== exp_w.next_expiry_ms) begin
                  $error("next_expiry_ms exp %0d got %0d", exp_w.next_expiry_ms,
                         rsp_tdata[85:38]);
                  error_count++;
               end
               if (rsp_tlast !== exp_w.last) begin
                  $error("last exp %0d got %0d", exp_w.last, rsp_tlast); error_count++;
               end
            end
            rsp_wait = stall_enable ? $urandom_range(0, 9) : 0;
         end else if (rsp_tvalid && rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   // corners: rejects, saturation, mode three, zero tick, stale absolute
   task automatic test_directed();
      start_slot(0, MODE_ONE_SHOT, 0, 16'd0, 32'h1111);            // zero value
      start_slot(0, MODE_ONE_SHOT, 0, 16'h8000, 32'h1);            // negative
      start_slot(0, MODE_ONE_SHOT, 1, 16'hFC18, 32'h1);            // exactly zero
      start_slot(0, MODE_ONE_SHOT, 0, 16'h7FFF, 32'hFFFFFFFF);
      start_slot(0, MODE_PERIODIC, 5, 16'd0, 32'h2);               // already running
      start_slot(15, MODE_PERIODIC, 0, 16'd3, 32'hA5A5A5A5);
      start_slot(7, MODE_THREE, 32'hFFFFFFFF, 16'h7FFF, 32'h0);     // largest start value
      start_slot(3, MODE_ABSOLUTE, 2, 16'd0, 32'h33);
      tick(0);
      tick(3);
      tick(3);
      set_epoch(0);
      set_epoch(1);
      start_slot(4, MODE_ABSOLUTE, 1, 16'd0, 32'h44);              // in the past
      set_epoch(5);                                               // absolute goes stale
      tick(0);
      stop_slot(9);                                               // idle slot
      stop_slot(15);
      tick(32'hFFFFFFFF);
      set_epoch(32'hFFFFFFFF);
      tick(32'hFFFFFFFF);
      drain_words();
   endtask

   // mostly short timers on all sixteen slots so they fire often
   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            start_slot(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                       ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 800) - 200),
                       $urandom);
         else if (pick < 50)
            stop_slot(4'($urandom_range(0, 15)));
         else if (pick < 90)
            tick(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 2500));
         else
            set_epoch(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20));
         if (n == count / 2) drain_words();  // hold off once until all words are back
      end
      drain_words();
   endtask

   task automatic test_no_stall(int count);
      stall_enable = 1'b0;
      test_random(count);
      stall_enable = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_active[i] = 1'b0; shadow_mode[i] = '0; shadow_remaining[i] = '0;
         shadow_reload[i] = '0; shadow_event[i] = '0;
      end
      shadow_now = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(350);
      test_no_stall(100);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // generous bound on the whole run
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
